[design/stem_pkg.sv]
// ----------------------------------------------------------------------------
// stem_pkg
// Shared types and constants of the spanning tree edge merger.
// ----------------------------------------------------------------------------
package stem_pkg;

    localparam int DEF_MAX_VERTICES = 1024;
    localparam int DEF_WEIGHT_BITS  = 20;

    localparam int VERTEX_W = 10;
    localparam int WEIGHT_W = 20;
    localparam int COUNT_W  = 11;
    localparam int TOTAL_W  = 30;
    localparam int RANK_W   = 4;
    localparam int LIMIT_W  = 17;
    localparam int ADDR_W   = 3;

    localparam logic [RANK_W-1:0]  RANK_MAX       = 4'd15;
    localparam logic [COUNT_W-1:0] VC_RESET_VALUE = 11'd1024;
    localparam logic               REG_VERTEX_COUNT = 1'b0;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FIND_A,
        ST_COMP_A,
        ST_FIND_B,
        ST_COMP_B,
        ST_UNION,
        ST_RANK,
        ST_EMIT
    } ctrl_state_t;

    typedef enum logic [2:0] {
        OP_IDLE,
        OP_CLEAR,
        OP_FIND,
        OP_COMP,
        OP_UNION,
        OP_RANK,
        OP_EMIT,
        OP_NONE
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   side_b;
        logic   accept;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic at_origin;
        logic comp_end;
        logic same_root;
        logic rank_up;
        logic bad;
        logic last;
        logic out_full;
        logic clr_last;
    } status_t;

endpackage

[design/spanning_tree_edge_merger.sv]
// ----------------------------------------------------------------------------
// spanning_tree_edge_merger
// Kruskal edge merger over a union-find forest with path compression.
// ----------------------------------------------------------------------------
// Edges arrive one per transfer and each yields one result transfer. The user
// must present them in ascending weight order; the block itself does not
// enforce it. The forest lives in a single memory with one read and one
// write port, and every link followed uses that read port. An edge is handled
// by finding the root of vertex_a and compressing its path where needed, then
// the same for vertex_b, then the union and, on a rank raise, a rank update,
// before the result is emitted; an edge with a bad endpoint goes straight to
// the result. The result stage waits while the previous result is still held.
// After reset and after each last edge the forest is swept over all
// MAX_VERTICES entries, during which no edge transfer is taken.
// ----------------------------------------------------------------------------
module spanning_tree_edge_merger #(
    parameter int MAX_VERTICES = stem_pkg::DEF_MAX_VERTICES,
    parameter int WEIGHT_BITS  = stem_pkg::DEF_WEIGHT_BITS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [39:0]                  s_tdata,   // vertex_a, vertex_b, edge_weight
    input  logic                         s_tlast,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [31:0]                  m_tdata,   // edge_taken, bad_endpoint, tree_weight
    output logic                         m_tlast,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [stem_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import stem_pkg::*;

    logic [COUNT_W-1:0] vc_reg;
    cmd_t               cmd;
    status_t            st;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_VERTEX_COUNT) ? 32'(vc_reg) : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vc_reg <= VC_RESET_VALUE;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_VERTEX_COUNT) begin
            vc_reg <= pwdata[COUNT_W-1:0];
        end
    end

    stem_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    stem_dp #(.MAX_VERTICES(MAX_VERTICES), .WEIGHT_BITS(WEIGHT_BITS)) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .st             (st),
        .in_vertex_a    (s_tdata[9:0]),
        .in_vertex_b    (s_tdata[19:10]),
        .in_edge_weight (s_tdata[39:20]),
        .in_last_edge   (s_tlast),
        .vertex_count   (vc_reg),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast)
    );
endmodule

[design/stem_ram.sv]
// ----------------------------------------------------------------------------
// stem_ram
// Generic RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module stem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[design/stem_dp.sv]
// ----------------------------------------------------------------------------
// stem_dp
// Datapath: union-find forest memory, root walks, union and running total.
// ----------------------------------------------------------------------------
module stem_dp #(
    parameter int MAX_VERTICES = stem_pkg::DEF_MAX_VERTICES,
    parameter int WEIGHT_BITS  = stem_pkg::DEF_WEIGHT_BITS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  stem_pkg::cmd_t                 cmd,
    output stem_pkg::status_t              st,
    input  logic [stem_pkg::VERTEX_W-1:0]  in_vertex_a,
    input  logic [stem_pkg::VERTEX_W-1:0]  in_vertex_b,
    input  logic [stem_pkg::WEIGHT_W-1:0]  in_edge_weight,
    input  logic                           in_last_edge,
    input  logic [stem_pkg::COUNT_W-1:0]   vertex_count,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [31:0]                    m_tdata,
    output logic                           m_tlast
);
    import stem_pkg::*;

    localparam int IDX_W  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int WORD_W = IDX_W + RANK_W;
    localparam logic [LIMIT_W-1:0] MAX_LIMIT = LIMIT_W'(MAX_VERTICES);
    localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(MAX_VERTICES - 1);
    localparam logic [WEIGHT_W-1:0] WMASK =
        (WEIGHT_BITS >= WEIGHT_W) ? {WEIGHT_W{1'b1}} : WEIGHT_W'((1 << WEIGHT_BITS) - 1);

    logic [IDX_W-1:0]    a_reg, a_next, b_reg, b_next, cur_reg, cur_next;
    logic [IDX_W-1:0]    root_a_reg, root_a_next, root_b_reg, root_b_next;
    logic [RANK_W-1:0]   rank_a_reg, rank_a_next, rank_b_reg, rank_b_next;
    logic [WEIGHT_W-1:0] w_reg, w_next;
    logic                last_reg, last_next, bad_reg, bad_next, taken_reg, taken_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic [IDX_W-1:0]    clr_reg, clr_next;
    logic                ovalid_reg, ovalid_next;
    logic [31:0]         odata_reg, odata_next;
    logic                olast_reg, olast_next;

    logic                we;
    logic [IDX_W-1:0]    waddr, raddr, q_parent, origin, root_sel;
    logic [WORD_W-1:0]   wdata, rdata;
    logic [RANK_W-1:0]   q_rank;
    logic [LIMIT_W-1:0]  vc_ext, limit;
    logic                in_bad;
    logic [TOTAL_W:0]    sum;

    stem_ram #(.WIDTH(WORD_W), .DEPTH(MAX_VERTICES)) u_forest (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign q_parent = rdata[IDX_W-1:0];
    assign q_rank   = rdata[IDX_W +: RANK_W];
    assign origin   = cmd.side_b ? b_reg : a_reg;
    assign root_sel = cmd.side_b ? root_b_reg : root_a_reg;

    assign vc_ext = LIMIT_W'(vertex_count);
    assign limit  = (vc_ext > MAX_LIMIT) ? MAX_LIMIT : vc_ext;
    assign in_bad = (LIMIT_W'(in_vertex_a) >= limit) || (LIMIT_W'(in_vertex_b) >= limit);
    assign sum    = (TOTAL_W+1)'(total_reg) + (TOTAL_W+1)'(w_reg);

    always_comb begin
        st.hit       = (q_parent == cur_reg);
        st.at_origin = (cur_reg == origin);
        st.comp_end  = (q_parent == root_sel);
        st.same_root = (root_a_reg == root_b_reg);
        st.rank_up   = (rank_a_reg == rank_b_reg) && (rank_a_reg != RANK_MAX);
        st.bad       = bad_reg;
        st.last      = last_reg;
        st.out_full  = ovalid_reg;
        st.clr_last  = (clr_reg == LAST_IDX);
    end

    always_comb begin
        a_next      = a_reg;
        b_next      = b_reg;
        cur_next    = cur_reg;
        root_a_next = root_a_reg;
        root_b_next = root_b_reg;
        rank_a_next = rank_a_reg;
        rank_b_next = rank_b_reg;
        w_next      = w_reg;
        last_next   = last_reg;
        bad_next    = bad_reg;
        taken_next  = taken_reg;
        total_next  = total_reg;
        clr_next    = clr_reg;
        ovalid_next = ovalid_reg && !m_tready;
        odata_next  = odata_reg;
        olast_next  = olast_reg;
        we          = 1'b0;
        waddr       = cur_reg;
        wdata       = {q_rank, root_sel};
        raddr       = q_parent;

        unique case (cmd.op)
            OP_IDLE: begin
                raddr = IDX_W'(in_vertex_a);
                if (cmd.accept) begin
                    a_next     = IDX_W'(in_vertex_a);
                    b_next     = IDX_W'(in_vertex_b);
                    cur_next   = IDX_W'(in_vertex_a);
                    w_next     = in_edge_weight & WMASK;
                    last_next  = in_last_edge;
                    bad_next   = in_bad;
                    taken_next = 1'b0;
                end
            end
            OP_CLEAR: begin
                we       = 1'b1;
                waddr    = clr_reg;
                wdata    = {{RANK_W{1'b0}}, clr_reg};
                clr_next = clr_reg + 1'b1;
            end
            OP_FIND: begin
                if (st.hit) begin
                    if (cmd.side_b) begin
                        root_b_next = cur_reg;
                        rank_b_next = q_rank;
                    end else begin
                        root_a_next = cur_reg;
                        rank_a_next = q_rank;
                    end
                    if (st.at_origin) begin
                        cur_next = b_reg;
                        raddr    = b_reg;
                    end else begin
                        cur_next = origin;
                        raddr    = origin;
                    end
                end else begin
                    cur_next = q_parent;
                end
            end
            OP_COMP: begin
                we = 1'b1;
                if (st.comp_end) begin
                    cur_next = b_reg;
                    raddr    = b_reg;
                end else begin
                    cur_next = q_parent;
                end
            end
            OP_UNION: begin
                taken_next = !st.same_root;
                if (!st.same_root) begin
                    we = 1'b1;
                    if (rank_a_reg < rank_b_reg) begin
                        waddr = root_a_reg;
                        wdata = {rank_a_reg, root_b_reg};
                    end else begin
                        waddr = root_b_reg;
                        wdata = {rank_b_reg, root_a_reg};
                    end
                    total_next = sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
                end
            end
            OP_RANK: begin
                we    = 1'b1;
                waddr = root_a_reg;
                wdata = {rank_a_reg + 1'b1, root_a_reg};
            end
            OP_EMIT: begin
                if (!ovalid_reg) begin
                    ovalid_next = 1'b1;
                    odata_next  = {total_reg, bad_reg, taken_reg};
                    olast_next  = last_reg;
                    if (last_reg) begin
                        total_next = '0;
                        clr_next   = '0;
                    end
                end
            end
            OP_NONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg  <= '0;
            clr_reg    <= '0;
            ovalid_reg <= 1'b0;
            bad_reg    <= 1'b0;
            last_reg   <= 1'b0;
        end else begin
            total_reg  <= total_next;
            clr_reg    <= clr_next;
            ovalid_reg <= ovalid_next;
            bad_reg    <= bad_next;
            last_reg   <= last_next;
        end
        a_reg      <= a_next;
        b_reg      <= b_next;
        cur_reg    <= cur_next;
        root_a_reg <= root_a_next;
        root_b_reg <= root_b_next;
        rank_a_reg <= rank_a_next;
        rank_b_reg <= rank_b_next;
        w_reg      <= w_next;
        taken_reg  <= taken_next;
        odata_reg  <= odata_next;
        olast_reg  <= olast_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;
    assign m_tlast  = olast_reg;

`ifndef SYNTHESIS
    // A node being compressed lies strictly below its root.
    a_comp_not_root: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_COMP) |-> (q_parent != cur_reg))
        else $error("compression walk reached a root");
    // The total never drops while a graph is in progress.
    a_total_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_UNION) |=> (total_reg >= $past(total_reg)))
        else $error("running total decreased");
    // A taken edge joins two different roots.
    a_taken_roots: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_UNION && st.same_root) |=> !taken_reg)
        else $error("edge taken within one set");
`endif
endmodule

[design/stem_ctrl.sv]
// ----------------------------------------------------------------------------
// stem_ctrl
// Controller: sequences root walks, compression, union, result and clearing.
// ----------------------------------------------------------------------------
module stem_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  stem_pkg::status_t st,
    output stem_pkg::cmd_t    cmd
);
    import stem_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:  if (st.clr_last) state_next = ST_IDLE;
            ST_IDLE:   if (s_tvalid) state_next = ST_FIND_A;
            ST_FIND_A: begin
                if (st.bad) begin
                    state_next = ST_EMIT;
                end else if (st.hit) begin
                    state_next = st.at_origin ? ST_FIND_B : ST_COMP_A;
                end
            end
            ST_COMP_A: if (st.comp_end) state_next = ST_FIND_B;
            ST_FIND_B: begin
                if (st.hit) begin
                    state_next = st.at_origin ? ST_UNION : ST_COMP_B;
                end
            end
            ST_COMP_B: if (st.comp_end) state_next = ST_UNION;
            ST_UNION: begin
                state_next = (!st.same_root && st.rank_up) ? ST_RANK : ST_EMIT;
            end
            ST_RANK:   state_next = ST_EMIT;
            ST_EMIT: begin
                if (!st.out_full) begin
                    state_next = st.last ? ST_CLEAR : ST_IDLE;
                end
            end
            default:   state_next = ST_CLEAR;
        endcase
    end

    always_comb begin
        cmd.op     = OP_NONE;
        cmd.side_b = 1'b0;
        cmd.accept = 1'b0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:  cmd.op = OP_CLEAR;
            ST_IDLE: begin
                cmd.op     = OP_IDLE;
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            ST_FIND_A: cmd.op = st.bad ? OP_NONE : OP_FIND;
            ST_COMP_A: cmd.op = OP_COMP;
            ST_FIND_B: begin
                cmd.op     = OP_FIND;
                cmd.side_b = 1'b1;
            end
            ST_COMP_B: begin
                cmd.op     = OP_COMP;
                cmd.side_b = 1'b1;
            end
            ST_UNION:  cmd.op = OP_UNION;
            ST_RANK:   cmd.op = OP_RANK;
            ST_EMIT:   cmd.op = OP_EMIT;
            default:   cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    // The forest is swept after the result of the last edge is placed in the output register.
    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && !st.out_full && st.last) |=> (state_reg == ST_CLEAR))
        else $error("last edge did not start a clearing sweep");
    // No edge is taken in while the forest is being cleared.
    a_no_accept_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !cmd.accept)
        else $error("edge accepted during clearing sweep");
    // A rank raise only follows a union.
    a_rank_after_union: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RANK) |-> ($past(state_reg) == ST_UNION))
        else $error("rank raise outside a union");
`endif
endmodule
